### rtl/pwst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_pkg: shared definitions for the PID regulator with settle timeout
// Field widths, default parameter values, item and register codes, and the
// stage enable bundle used between the top level and the term units.
// ----------------------------------------------------------------------------
package pwst_pkg;

  localparam int unsigned SumWidthDef     = 32;
  localparam int unsigned GainFracBitsDef = 8;

  localparam int unsigned RegW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned ChgW    = 18;
  localparam int unsigned TimerW  = 17;
  localparam int unsigned TermW   = 32;

  localparam logic [TimerW-1:0] TimerMax = '1;

  // Item codes
  localparam logic [FuncW-1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_TICK    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RESTART = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FEED_FORWARD = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_ZONE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_BAND  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RUN_LIMIT    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_LIMIT = 3'd7;

  localparam logic [RegW-1:0] GainPReset = 16'd256;

  // Load enables for the product and term stages
  typedef struct packed {
    logic mul_en;
    logic sat_en;
  } stage_en_t;

endpackage

### rtl/pwst_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_term: gain product, fractional shift and saturation
// Two register stages: the signed product of a state value and a Q-format
// gain, then the product shifted down by the fraction bits (floor) and
// clamped to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pwst_term #(
  parameter int unsigned X_WIDTH        = 17,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                     clk_i,
  input  pwst_pkg::stage_en_t                      en_i,
  input  logic signed [X_WIDTH-1:0]                x_i,
  input  logic signed [pwst_pkg::RegW-1:0]         gain_i,
  output logic signed [pwst_pkg::TermW-1:0]        term_o
);
  import pwst_pkg::*;

  localparam int unsigned ProdW = X_WIDTH + RegW;
  localparam int unsigned ExtW  = (ProdW > TermW) ? ProdW : TermW + 1;

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] shifted;
  logic signed [ExtW-1:0]  wide;
  logic signed [TermW-1:0] term_d;
  logic signed [TermW-1:0] term_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= ProdW'(x_i) * ProdW'(gain_i);
    end
  end

  always_comb begin
    // arithmetic shift rounds toward minus infinity
    shifted = prod_q >>> GAIN_FRAC_BITS;
    wide    = ExtW'(shifted);
    if ((&wide[ExtW-1:TermW-1]) || !(|wide[ExtW-1:TermW-1])) begin
      term_d = wide[TermW-1:0];
    end else begin
      term_d = {wide[ExtW-1], {(TermW-1){~wide[ExtW-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat_en) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

### rtl/pid_with_settle_timeout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_settle_timeout_top: discrete PID regulator with integral zone
// Samples, millisecond ticks and restarts update the regulator state; each
// item yields one result with drive, the three terms and the timeout flag.
// ----------------------------------------------------------------------------
// Every transfer in produces one result, and a new item is taken in every
// cycle while in_stall_o is low. The regulator state (error, integral,
// derivative, timers) updates in the cycle of the transfer; the result then
// goes through a product register, a shift-and-clamp register and the output
// register, where the drive sum is formed. Output stall backs up through the
// stages and only reaches in_stall_o when every stage is full. The drive
// reported for ticks and restarts is the one from the most recent sample.
module pid_with_settle_timeout_top #(
  parameter int unsigned SUM_WIDTH      = pwst_pkg::SumWidthDef,
  parameter int unsigned GAIN_FRAC_BITS = pwst_pkg::GainFracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_we_i,
  input  logic [pwst_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [pwst_pkg::RegW-1:0]             cfg_data_i,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pwst_pkg::FuncW-1:0]            func_i,
  input  logic signed [pwst_pkg::RegW-1:0]      target_i,
  input  logic signed [pwst_pkg::RegW-1:0]      feedback_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pwst_pkg::TermW-1:0]     drive_o,
  output logic signed [pwst_pkg::TermW-1:0]     p_term_o,
  output logic signed [pwst_pkg::TermW-1:0]     i_term_o,
  output logic signed [pwst_pkg::TermW-1:0]     d_term_o,
  output logic                                  completed_o
);
  import pwst_pkg::*;

  localparam int unsigned DriveSumW = TermW + 2;

  // Configuration registers
  logic signed [RegW-1:0] gain_p_q, gain_i_q, gain_d_q, ff_q;
  logic [RegW-1:0]        izone_q, sband_q, run_lim_q, settle_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= GainPReset;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      ff_q         <= '0;
      izone_q      <= '0;
      sband_q      <= '0;
      run_lim_q    <= '0;
      settle_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_P:        gain_p_q     <= cfg_data_i;
        REG_GAIN_I:        gain_i_q     <= cfg_data_i;
        REG_GAIN_D:        gain_d_q     <= cfg_data_i;
        REG_FEED_FORWARD:  ff_q         <= cfg_data_i;
        REG_INTEGRAL_ZONE: izone_q      <= cfg_data_i;
        REG_SETTLE_BAND:   sband_q      <= cfg_data_i;
        REG_RUN_LIMIT:     run_lim_q    <= cfg_data_i;
        REG_SETTLE_LIMIT:  settle_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic in_xfer;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q;
    end
  end

  // Regulator state; after a transfer these registers are stage one
  logic signed [ErrW-1:0]      err_q, err_d;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic signed [ChgW-1:0]      chg_q, chg_d;
  logic [TimerW-1:0]           run_q, run_d, settle_q, settle_d;
  logic                        s1_sample_q;

  logic signed [ErrW-1:0]      err_new;
  logic [ErrW-1:0]             err_mag;
  logic signed [SUM_WIDTH:0]   sum_ext;

  always_comb begin
    err_new = ErrW'(target_i) - ErrW'(feedback_i);
    err_mag = err_new[ErrW-1] ? ErrW'(-err_new) : ErrW'(err_new);
    sum_ext = (SUM_WIDTH + 1)'(sum_q) + (SUM_WIDTH + 1)'(err_new);

    err_d    = err_q;
    sum_d    = sum_q;
    chg_d    = chg_q;
    run_d    = run_q;
    settle_d = settle_q;

    if (func_i == FUNC_SAMPLE) begin
      err_d = err_new;
      chg_d = ChgW'(err_q) - ChgW'(err_new);
      if (err_mag < {1'b0, izone_q}) begin
        // clamp the integral at the accumulator limits
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
          sum_d = {sum_ext[SUM_WIDTH], {(SUM_WIDTH-1){~sum_ext[SUM_WIDTH]}}};
        end else begin
          sum_d = sum_ext[SUM_WIDTH-1:0];
        end
      end else begin
        sum_d = '0;
      end
      if (err_mag > {1'b0, sband_q}) begin
        settle_d = '0;
      end
    end else if (func_i == FUNC_TICK) begin
      if (run_q != TimerMax)    run_d    = run_q + TimerW'(1);
      if (settle_q != TimerMax) settle_d = settle_q + TimerW'(1);
    end else if (func_i == FUNC_RESTART) begin
      err_d    = '0;
      sum_d    = '0;
      chg_d    = '0;
      run_d    = '0;
      settle_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= '0;
      sum_q       <= '0;
      chg_q       <= '0;
      run_q       <= '0;
      settle_q    <= '0;
      s1_sample_q <= 1'b0;
    end else if (in_xfer) begin
      err_q       <= err_d;
      sum_q       <= sum_d;
      chg_q       <= chg_d;
      run_q       <= run_d;
      settle_q    <= settle_d;
      s1_sample_q <= (func_i == FUNC_SAMPLE);
    end
  end

  // Stage two and three side band
  logic s2_sample_q, s2_done_q, s3_sample_q, s3_done_q;
  logic done_d;

  assign done_d = ((run_lim_q != '0) && (run_q > {1'b0, run_lim_q})) ||
                  ((settle_lim_q != '0) && (settle_q > {1'b0, settle_lim_q}));

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_sample_q <= s1_sample_q;
      s2_done_q   <= done_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_sample_q <= s2_sample_q;
      s3_done_q   <= s2_done_q;
    end
  end

  // Term units
  stage_en_t term_en;
  logic signed [TermW-1:0] p_s3, i_s3, d_s3;

  assign term_en.mul_en = s2_ready && s1_valid_q;
  assign term_en.sat_en = s3_ready && s2_valid_q;

  pwst_term #(
    .X_WIDTH        (ErrW),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_term_p (
    .clk_i  (clk_i),
    .en_i   (term_en),
    .x_i    (err_q),
    .gain_i (gain_p_q),
    .term_o (p_s3)
  );

  pwst_term #(
    .X_WIDTH        (SUM_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_term_i (
    .clk_i  (clk_i),
    .en_i   (term_en),
    .x_i    (sum_q),
    .gain_i (gain_i_q),
    .term_o (i_s3)
  );

  pwst_term #(
    .X_WIDTH        (ChgW),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_term_d (
    .clk_i  (clk_i),
    .en_i   (term_en),
    .x_i    (chg_q),
    .gain_i (gain_d_q),
    .term_o (d_s3)
  );

  // Output stage; drive_q doubles as the held drive between samples
  logic signed [DriveSumW-1:0] drive_sum;
  logic signed [TermW-1:0]     drive_sat;
  logic signed [TermW-1:0]     drive_q, p_q, i_q, d_q;
  logic                        done_q;

  always_comb begin
    drive_sum = DriveSumW'(p_s3) + DriveSumW'(i_s3) + DriveSumW'(d_s3) + DriveSumW'(ff_q);
    if ((&drive_sum[DriveSumW-1:TermW-1]) || !(|drive_sum[DriveSumW-1:TermW-1])) begin
      drive_sat = drive_sum[TermW-1:0];
    end else begin
      drive_sat = {drive_sum[DriveSumW-1], {(TermW-1){~drive_sum[DriveSumW-1]}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
    end else if (out_ready && s3_valid_q && s3_sample_q) begin
      drive_q <= drive_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      p_q    <= p_s3;
      i_q    <= i_s3;
      d_q    <= d_s3;
      done_q <= s3_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign p_term_o    = p_q;
  assign i_term_o    = i_q;
  assign d_term_o    = d_q;
  assign completed_o = done_q;

endmodule
